FILE: rtl/xdk_pkg.sv
// Shared types, constants and tables for the X-drive velocity loop.
// No dependencies; imported by xdk_cfg_regs and the top-level unit.
package xdk_pkg;

    localparam int CordicStepsDef = 16;
    localparam int CordicStepsMax = 24;
    localparam int DutyLimit      = 16384;
    localparam int InvGain        = 39797;
    localparam int DegToRadQ24    = 292818;

    localparam logic [2:0] REG_FULL_SPEED      = 3'd0;
    localparam logic [2:0] REG_ROTATE_FRACTION = 3'd1;
    localparam logic [2:0] REG_MAX_ROTATE_RATE = 3'd2;
    localparam logic [2:0] REG_WHEEL_ARM       = 3'd3;
    localparam logic [2:0] REG_VELOCITY_GAIN   = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROT0,
        ST_ROT1,
        ST_ROT2,
        ST_ROT3,
        ST_CORDIC,
        ST_GX,
        ST_GY,
        ST_SX,
        ST_SY,
        ST_WHEEL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [14:0] full_speed;
        logic [14:0] rotate_fraction;
        logic [10:0] max_rotate_rate;
        logic [11:0] wheel_arm;
        logic [15:0] velocity_gain;
    } cfg_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0:  v = 32'h20000000;
                5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;
                5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;
                5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;
                5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;
                5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;
                5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;
                5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;
                5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;
                5'd23: v = 32'h00000051;
                default: v = 32'h0;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: rtl/xdk_cfg_regs.sv
// Configuration register file of the X-drive velocity loop.
// Depends on xdk_pkg.
module xdk_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output xdk_pkg::cfg_t      cfg
);
    import xdk_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_speed      <= 15'd4096;
            cfg_reg.rotate_fraction <= 15'd16384;
            cfg_reg.max_rotate_rate <= 11'd360;
            cfg_reg.wheel_arm       <= 12'd512;
            cfg_reg.velocity_gain   <= 16'd1311;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FULL_SPEED:      cfg_reg.full_speed      <= cfg_data[14:0];
                REG_ROTATE_FRACTION: cfg_reg.rotate_fraction <= cfg_data[14:0];
                REG_MAX_ROTATE_RATE: cfg_reg.max_rotate_rate <= cfg_data[10:0];
                REG_WHEEL_ARM:       cfg_reg.wheel_arm       <= cfg_data[11:0];
                REG_VELOCITY_GAIN:   cfg_reg.velocity_gain   <= cfg_data;
                default: ;
            endcase
        end
    end
endmodule

FILE: rtl/xdk_mul.sv
// Shared signed multiplier with a registered product.
// No dependencies.
module xdk_mul (
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [63:0] p
);
    logic signed [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;
endmodule

FILE: rtl/xdrive_kinematics_velocity_loop_unit.sv
// X-drive inverse kinematics with per-wheel velocity loop, top level.
// Sequence: ROT0 to ROT3, the CORDIC step loop, GX, GY, SX, SY, then WHEEL and DONE per wheel.
// A new item is accepted only once the last result has been taken; the rate is set
// by the shared CORDIC step loop and the one shared multiplier.
// Reset: duty state cleared to zero, configuration registers to their defaults; the result register
// holds until taken and a new item is accepted once it is.
module xdrive_kinematics_velocity_loop_unit #(
    parameter int CORDIC_STEPS = xdk_pkg::CordicStepsDef
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] forward_cmd,
    input  logic signed [15:0] strafe_cmd,
    input  logic signed [15:0] rotate_cmd,
    input  logic signed [15:0] heading,
    input  logic signed [15:0] front_left_velocity,
    input  logic signed [15:0] front_right_velocity,
    input  logic signed [15:0] rear_left_velocity,
    input  logic signed [15:0] rear_right_velocity,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] front_left_out,
    output logic signed [15:0] front_right_out,
    output logic signed [15:0] rear_left_out,
    output logic signed [15:0] rear_right_out
);
    import xdk_pkg::*;

    localparam int NSteps = (CORDIC_STEPS < CordicStepsMax) ? CORDIC_STEPS : CordicStepsMax;

    cfg_t cfg;
    state_t state_reg, state_next;

    logic [4:0]          cnt_reg, cnt_next;
    logic [1:0]          wh_reg, wh_next;
    logic signed [35:0]  x_reg, x_next, y_reg, y_next;
    logic signed [33:0]  z_reg, z_next;
    logic signed [31:0]  acc_reg, acc_next;
    logic signed [31:0]  tx_reg, tx_next, ty_reg, ty_next;
    logic signed [31:0]  r_reg, r_next;
    logic signed [63:0]  rhi_reg;
    logic signed [15:0]  vel_reg [4];
    logic signed [15:0]  duty_reg [4];
    logic signed [15:0]  duty_new;
    logic                duty_we;
    logic signed [15:0]  rot_reg, fwd_reg, str_reg, hd_reg;
    logic                out_valid_reg, out_valid_next;
    logic signed [31:0]  ma, mb;
    logic signed [63:0]  mp;
    logic [31:0]         zq;
    logic [1:0]          q;
    logic signed [35:0]  sx, sy, dx, dy;
    logic signed [31:0]  lim, target;
    logic signed [47:0]  dsum;
    logic                accept;

    xdk_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    xdk_mul u_mul (
        .clk(clk),
        .a  (ma),
        .b  (mb),
        .p  (mp)
    );

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign front_left_out  = duty_reg[0];
    assign front_right_out = duty_reg[1];
    assign rear_left_out   = duty_reg[2];
    assign rear_right_out  = duty_reg[3];

    assign lim = 32'(cfg.rotate_fraction);
    // quarter-turn fold of (heading - 45 deg)
    assign zq  = {hd_reg + 16'shE000, 16'h0};
    assign q   = 2'((zq + 32'h20000000) >> 30);
    assign dx  = y_reg >>> cnt_reg;
    assign dy  = x_reg >>> cnt_reg;

    always_comb
    begin
        case (wh_reg)
            2'd0:    target = tx_reg + r_reg;
            2'd1:    target = -ty_reg + r_reg;
            2'd2:    target = ty_reg + r_reg;
            default: target = -tx_reg + r_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        wh_next        = wh_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        acc_next       = acc_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        r_next         = r_reg;
        out_valid_next = out_valid_reg;
        ma             = '0;
        mb             = '0;
        sx             = '0;
        sy             = '0;
        dsum           = '0;
        duty_new       = '0;
        duty_we        = 1'b0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_ROT0;
            end
            ST_ROT0:
            begin
                ma = 32'(rot_reg);
                mb = lim;
                case (q)
                    2'd0:
                    begin
                        sx = 36'(str_reg) <<< 14;
                        sy = -(36'(fwd_reg) <<< 14);
                    end
                    2'd1:
                    begin
                        sx = 36'(fwd_reg) <<< 14;
                        sy = 36'(str_reg) <<< 14;
                    end
                    2'd2:
                    begin
                        sx = -(36'(str_reg) <<< 14);
                        sy = 36'(fwd_reg) <<< 14;
                    end
                    default:
                    begin
                        sx = -(36'(fwd_reg) <<< 14);
                        sy = -(36'(str_reg) <<< 14);
                    end
                endcase
                x_next     = sx;
                y_next     = sy;
                z_next     = 34'(signed'(zq - {q, 30'h0}));
                cnt_next   = '0;
                state_next = ST_ROT1;
            end
            ST_ROT1:
            begin
                acc_next = 32'(mp >>> 14);
                if ((mp >>> 14) > 64'(lim))
                    acc_next = lim;
                else if ((mp >>> 14) < -64'(lim))
                    acc_next = -lim;
                // rate * radius on the shared multiplier, used next cycle
                ma = 32'(cfg.max_rotate_rate);
                mb = 32'(cfg.wheel_arm);
                state_next = ST_ROT2;
            end
            ST_ROT2:
            begin
                ma = acc_reg;
                mb = 32'(mp);
                state_next = ST_ROT3;
            end
            ST_ROT3:
            begin
                // rotate * rate * radius fits in 39 bits; product with pi/180 in Q24 next
                acc_next   = 32'(mp >>> 14);
                r_next     = 32'(mp[13:0]);
                state_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                if (z_reg >= 0)
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - 34'(atan_entry(cnt_reg));
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + 34'(atan_entry(cnt_reg));
                end
                cnt_next = cnt_reg + 5'd1;
                if (32'(cnt_reg) == NSteps - 1)
                    state_next = ST_GX;
                // rim speed: high part at step 0, low part at step 1, summed at step 2
                ma = acc_reg;
                mb = DegToRadQ24;
                if (cnt_reg == 5'd0)
                    tx_next = 32'(mp >>> 0) ;
                if (cnt_reg == 5'd1)
                    ty_next = 32'(mp);
                if (cnt_reg == 5'd0)
                    ma = acc_reg;
                else
                begin
                    ma = r_reg;
                    mb = DegToRadQ24;
                end
            end
            ST_GX:
            begin
                ma = 32'(x_reg);
                mb = InvGain;
                state_next = ST_GY;
            end
            ST_GY:
            begin
                acc_next   = 32'(mp >>> 16);
                ma         = 32'(y_reg);
                mb         = InvGain;
                state_next = ST_SX;
            end
            ST_SX:
            begin
                ma         = acc_reg;
                mb         = 32'(cfg.full_speed);
                acc_next   = 32'(mp >>> 16);
                state_next = ST_SY;
            end
            ST_SY:
            begin
                tx_next    = 32'(mp >>> 28);
                ma         = acc_reg;
                mb         = 32'(cfg.full_speed);
                wh_next    = 2'd0;
                state_next = ST_WHEEL;
            end
            ST_WHEEL:
            begin
                if (wh_reg == 2'd0)
                    ty_next = 32'(mp >>> 28);
                ma         = target - 32'(vel_reg[wh_reg]);
                mb         = 32'(cfg.velocity_gain);
                if (wh_reg == 2'd0)
                    ma = (tx_reg + r_reg) - 32'(vel_reg[0]);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                dsum = 48'(duty_reg[wh_reg]) + 48'(mp >>> 12);
                if (dsum > 48'(DutyLimit))
                    duty_new = 16'(DutyLimit);
                else if (dsum < -48'(DutyLimit))
                    duty_new = -16'(DutyLimit);
                else
                    duty_new = 16'(dsum);
                duty_we = 1'b1;
                if (wh_reg == 2'd3)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    wh_next    = wh_reg + 2'd1;
                    state_next = ST_WHEEL;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // r: rotate*rate*radius = acc*2^14 + low; times K, then >> 38
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CORDIC && cnt_reg == 5'd1)
            rhi_reg <= mp;
        if (state_reg == ST_CORDIC && cnt_reg == 5'd2)
            r_reg <= 32'(((rhi_reg <<< 14) + mp) >>> 38);
        else
            r_reg <= r_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
                duty_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (duty_we)
                duty_reg[wh_reg] <= duty_new;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        wh_reg  <= wh_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        acc_reg <= acc_next;
        tx_reg  <= tx_next;
        ty_reg  <= ty_next;
        if (accept)
        begin
            fwd_reg    <= forward_cmd;
            str_reg    <= strafe_cmd;
            rot_reg    <= rotate_cmd;
            hd_reg     <= heading;
            vel_reg[0] <= front_left_velocity;
            vel_reg[1] <= front_right_velocity;
            vel_reg[2] <= rear_left_velocity;
            vel_reg[3] <= rear_right_velocity;
        end
    end

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready) else $error("ready while busy");
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (front_left_out <= 16'sd16384 && front_left_out >= -16'sd16384))
        else $error("duty out of range");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(front_left_out)))
        else $error("result dropped");
endmodule
